[hw/rtl/imm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imm_pkg: shared types and codes for the integer matrix multiply/power block
// Field widths, item modes, register indexes, storage bank codes and the
// control structs that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

   // fixed widths of the channel fields
   localparam int MODE_W     = 2;
   localparam int POS_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int DIM_W      = 4;
   localparam int POWER_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int BANK_W     = 2;

   // input item modes
   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_COLS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OP_SELECT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POWER     = 3'd4;

   // operation select
   localparam logic OP_MULTIPLY = 1'b0;
   localparam logic OP_POWER    = 1'b1;

   // storage banks inside the shared matrix memory
   localparam logic [BANK_W-1:0] BANK_A    = 2'd0;
   localparam logic [BANK_W-1:0] BANK_B    = 2'd1;
   localparam logic [BANK_W-1:0] BANK_WORK = 2'd2;
   localparam logic [BANK_W-1:0] BANK_PROD = 2'd3;

   // strobes from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic load_x;   // capture the left operand from memory read data
      logic mul_en;   // register x * read data
      logic acc_en;   // add product into the accumulator
      logic first;    // first term of a dot product: start from zero
   } mac_ctrl_type;

   // result word request from the sequencer
   typedef struct packed {
      logic             load;
      logic             last;
      logic             error;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } emit_type;

endpackage
`default_nettype wire

[hw/rtl/integer_matrix_multiply_power.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_multiply_power: matrix multiply and matrix power engine
// Loads A and B element by element, then computes A*B or A^power with one
// shared multiply-accumulate unit and streams the result matrix out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: mode 0/1 writes one element of A/B at (row, col); each
//    load word gives no result. Mode 2 starts the job.
//  - rsp channel: result words in row-major order, last set on the final
//    one; power above 1 on a non-square A gives one word with error set.
//  - csr channel: always ready; write registers only while the block is idle.
//  - Each dot-product term steps through read A, read B, multiply and
//    accumulate through the single read port of the matrix memory; a
//    multiply pass covers n*k*m terms and power mode (power-1) passes of
//    n^3 terms. Each result word then takes a memory read and an output.
//  - req_ready is low from start until the last result word is loaded into
//    the output register; a stalled rsp_ready holds the sequencer there.
//  - Reset clears the control state and the registers to a_rows = a_cols =
//    b_cols = 1, op_select = 0, power = 0; matrix contents are undefined
//    until loaded. No clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_power #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   // input words
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [imm_pkg::MODE_W-1:0]       req_mode,
   input  wire [imm_pkg::POS_W-1:0]        req_row,
   input  wire [imm_pkg::POS_W-1:0]        req_col,
   input  wire signed [imm_pkg::VALUE_W-1:0] req_value,
   // result words
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [imm_pkg::POS_W-1:0]       rsp_out_row,
   output logic [imm_pkg::POS_W-1:0]       rsp_out_col,
   output logic signed [imm_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                            rsp_last,
   output logic                            rsp_error,
   // register writes
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [imm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [imm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import imm_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = BANK_W + 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

   // last index of a dimension register, with 0 read as 1 and large as MAX_DIM
   function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] c;
      c = d;
      if (d == '0) begin
         c = DIM_W'(1);
      end else if (d > MAX_DIM_C) begin
         c = MAX_DIM_C;
      end
      return IDX_W'(c - DIM_W'(1));
   endfunction

   // configuration registers
   logic [DIM_W-1:0]   a_rows_ff, a_cols_ff, b_cols_ff;
   logic               op_select_ff;
   logic [POWER_W-1:0] power_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= DIM_W'(1);
         a_cols_ff    <= DIM_W'(1);
         b_cols_ff    <= DIM_W'(1);
         op_select_ff <= OP_MULTIPLY;
         power_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_A_ROWS:    a_rows_ff    <= csr_data[DIM_W-1:0];
            REG_A_COLS:    a_cols_ff    <= csr_data[DIM_W-1:0];
            REG_B_COLS:    b_cols_ff    <= csr_data[DIM_W-1:0];
            REG_OP_SELECT: op_select_ff <= csr_data[0];
            REG_POWER:     power_ff     <= csr_data[POWER_W-1:0];
            default: ;
         endcase
      end
   end

   // input word decode
   logic                  req_take;
   logic                  is_load;
   logic                  in_range;
   logic                  load_we;
   logic                  start;
   logic [ADDR_W-1:0]     load_addr;
   logic [BANK_W-1:0]     load_bank;

   assign req_take  = req_valid && req_ready;
   assign is_load   = (req_mode == MODE_LOAD_A) || (req_mode == MODE_LOAD_B);
   assign in_range  = ({1'b0, req_row} < MAX_DIM_C) && ({1'b0, req_col} < MAX_DIM_C);
   assign load_we   = req_take && is_load && in_range;
   assign start     = req_take && (req_mode == MODE_START);
   assign load_bank = (req_mode == MODE_LOAD_A) ? BANK_A : BANK_B;
   assign load_addr = {load_bank, req_row[IDX_W-1:0], req_col[IDX_W-1:0]};

   // sequencer
   logic                  seq_idle;
   logic                  out_free;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  seq_we;
   logic [ADDR_W-1:0]     seq_waddr;
   mac_ctrl_type          mac_ctrl;
   emit_type              emit;

   assign req_ready = seq_idle;

   imm_seq #(
      .IDX_W   (IDX_W),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op_sel   (op_select_ff),
      .power    (power_ff),
      .nr_last  (dim_last(a_rows_ff)),
      .nc_last  (dim_last(a_cols_ff)),
      .mb_last  (dim_last(b_cols_ff)),
      .out_free (out_free),
      .idle     (seq_idle),
      .rd_addr  (rd_addr),
      .wr_en    (seq_we),
      .wr_addr  (seq_waddr),
      .mac_ctrl (mac_ctrl),
      .emit     (emit)
   );

   // shared matrix memory: banks A, B, work, product
   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] mac_sum;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   assign mem_we    = load_we || seq_we;
   assign mem_waddr = seq_we ? seq_waddr : load_addr;
   assign mem_wdata = seq_we ? mac_sum : req_value[DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   imm_mac #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .rd_data (rd_data_ff),
      .sum     (mac_sum)
   );

   // output register
   logic                  rsp_valid_ff;
   logic [POS_W-1:0]      row_ff, col_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic                  last_ff, error_ff;
   logic [VALUE_W-1:0]    value_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign value_in = emit.error ? '0 : VALUE_W'($signed(rd_data_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.load) begin
         row_ff   <= emit.row;
         col_ff   <= emit.col;
         value_ff <= value_in;
         last_ff  <= emit.last;
         error_ff <= emit.error;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = error_ff;

   // checks
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> out_free)
      else $error("result loaded over a word not yet taken");

   a_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(load_we && seq_we))
      else $error("load write collides with a job write");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && rsp_out_value == '0))
      else $error("error word must be the last and carry zero");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("block took a start word but stayed ready");

endmodule
`default_nettype wire

[hw/rtl/imm_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imm_mac: shared multiply-accumulate unit
// Takes both operands from the memory read port one after the other,
// registers their wrapped product, then accumulates it into a running sum.
// ----------------------------------------------------------------------------
module imm_mac #(
   parameter int DATA_WIDTH = 32
) (
   input  wire                       clock,
   input  wire imm_pkg::mac_ctrl_type ctrl,
   input  wire [DATA_WIDTH-1:0]      rd_data,
   output logic [DATA_WIDTH-1:0]     sum
);
   import imm_pkg::*;

   logic [DATA_WIDTH-1:0]   x_ff;
   logic [DATA_WIDTH-1:0]   prod_ff;
   logic [DATA_WIDTH-1:0]   acc_ff;
   logic [2*DATA_WIDTH-1:0] full_prod;
   logic [DATA_WIDTH-1:0]   acc_base;

   // product wraps at the data width
   assign full_prod = (2*DATA_WIDTH)'(x_ff) * (2*DATA_WIDTH)'(rd_data);

   // running sum; first term starts over from zero
   assign acc_base = ctrl.first ? '0 : acc_ff;
   assign sum      = acc_base + prod_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_x) begin
         x_ff <= rd_data;
      end
      if (ctrl.mul_en) begin
         prod_ff <= full_prod[DATA_WIDTH-1:0];
      end
      if (ctrl.acc_en) begin
         acc_ff <= sum;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/imm_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imm_seq: job sequencer
// Walks row, column and term counters over the shared matrix memory, drives
// the multiply-accumulate unit term by term, ping-pongs the work
// and product banks between power passes, then streams the result out.
// ----------------------------------------------------------------------------
module imm_seq #(
   parameter int IDX_W   = 3,
   parameter int ADDR_W  = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire                         op_sel,
   input  wire [imm_pkg::POWER_W-1:0]  power,
   input  wire [IDX_W-1:0]             nr_last,
   input  wire [IDX_W-1:0]             nc_last,
   input  wire [IDX_W-1:0]             mb_last,
   input  wire                         out_free,
   output logic                        idle,
   output logic [ADDR_W-1:0]           rd_addr,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output imm_pkg::mac_ctrl_type       mac_ctrl,
   output imm_pkg::emit_type           emit
);
   import imm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RD_X   = 3'd1;
   localparam logic [2:0] ST_RD_Y   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_ACC    = 3'd4;
   localparam logic [2:0] ST_EM_RD  = 3'd5;
   localparam logic [2:0] ST_EM_OUT = 3'd6;
   localparam logic [2:0] ST_ERROR  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [IDX_W-1:0]   n_ff, n_in, k_ff, k_in, m_ff, m_in;
   logic [BANK_W-1:0]  xb_ff, xb_in, yb_ff, yb_in, db_ff, db_in;
   logic [POWER_W-1:0] passes_ff, passes_in;
   logic               t_end, j_end, i_end;

   assign t_end = (t_ff == k_ff);
   assign j_end = (j_ff == m_ff);
   assign i_end = (i_ff == n_ff);

   assign idle = (state_ff == ST_IDLE);

   // memory addresses: row-major inside each bank
   always_comb begin
      unique case (state_ff)
         ST_RD_X: rd_addr = {xb_ff, i_ff, t_ff};
         ST_RD_Y: rd_addr = {yb_ff, t_ff, j_ff};
         default: rd_addr = {db_ff, i_ff, j_ff};
      endcase
   end

   assign wr_en   = (state_ff == ST_ACC) && t_end;
   assign wr_addr = {db_ff, i_ff, j_ff};

   // multiply-accumulate strobes
   always_comb begin
      mac_ctrl.load_x = (state_ff == ST_RD_Y);
      mac_ctrl.mul_en = (state_ff == ST_MUL);
      mac_ctrl.acc_en = (state_ff == ST_ACC);
      mac_ctrl.first  = (t_ff == '0);
   end

   // next-state and counter logic
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      xb_in     = xb_ff;
      yb_in     = yb_ff;
      db_in     = db_ff;
      passes_in = passes_ff;
      emit      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            t_in = '0;
            if (start) begin
               if (op_sel == OP_MULTIPLY) begin
                  xb_in     = BANK_A;
                  yb_in     = BANK_B;
                  db_in     = BANK_WORK;
                  n_in      = nr_last;
                  k_in      = nc_last;
                  m_in      = mb_last;
                  passes_in = POWER_W'(1);
                  state_in  = ST_RD_X;
               end else if (power <= POWER_W'(1)) begin
                  // return A as loaded
                  db_in    = BANK_A;
                  n_in     = nr_last;
                  m_in     = nc_last;
                  state_in = ST_EM_RD;
               end else if (nr_last != nc_last) begin
                  state_in = ST_ERROR;
               end else begin
                  xb_in     = BANK_A;
                  yb_in     = BANK_A;
                  db_in     = BANK_WORK;
                  n_in      = nr_last;
                  k_in      = nr_last;
                  m_in      = nr_last;
                  passes_in = power - POWER_W'(1);
                  state_in  = ST_RD_X;
               end
            end
         end
         ST_RD_X:  state_in = ST_RD_Y;
         ST_RD_Y:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_RD_X;
            if (!t_end) begin
               t_in = t_ff + IDX_W'(1);
            end else begin
               t_in = '0;
               if (!j_end) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     i_in = '0;
                     // pass done: emit, or feed this result into the next pass
                     if (passes_ff == POWER_W'(1)) begin
                        state_in = ST_EM_RD;
                     end else begin
                        passes_in = passes_ff - POWER_W'(1);
                        xb_in     = db_ff;
                        db_in     = (db_ff == BANK_WORK) ? BANK_PROD : BANK_WORK;
                     end
                  end
               end
            end
         end
         ST_EM_RD: state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (out_free) begin
               emit.load = 1'b1;
               emit.last = i_end && j_end;
               emit.row  = POS_W'(i_ff);
               emit.col  = POS_W'(j_ff);
               state_in  = ST_EM_RD;
               if (!j_end) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     i_in     = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               emit.load  = 1'b1;
               emit.last  = 1'b1;
               emit.error = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      m_ff      <= m_in;
      xb_ff     <= xb_in;
      yb_ff     <= yb_in;
      db_ff     <= db_in;
      passes_ff <= passes_in;
   end

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_matrix_multiply_power
// Loads A and B element by element, starts multiply and power jobs over a
// range of register settings, and checks every result word against a local
// prediction of the block, with random idling on the request side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import imm_pkg::*;

   // mode code the block leaves unused
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int DIM_MAX         = 8;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               error;
   } result_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   wire                   req_ready;
   logic [MODE_W-1:0]     req_mode  = MODE_LOAD_A;
   logic [POS_W-1:0]      req_row   = '0;
   logic [POS_W-1:0]      req_col   = '0;
   logic [VALUE_W-1:0]    req_value = '0;
   wire                   rsp_valid;
   logic                  rsp_ready = 1'b0;
   wire [POS_W-1:0]       rsp_out_row;
   wire [POS_W-1:0]       rsp_out_col;
   wire [VALUE_W-1:0]     rsp_out_value;
   wire                   rsp_last;
   wire                   rsp_error;
   logic                  csr_valid = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_A_ROWS;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // predicted contents of the matrix stores
   logic [VALUE_W-1:0] a_mat   [DIM_MAX*DIM_MAX];
   logic [VALUE_W-1:0] b_mat   [DIM_MAX*DIM_MAX];
   logic [VALUE_W-1:0] acc_mat [DIM_MAX*DIM_MAX];
   logic [VALUE_W-1:0] tmp_mat [DIM_MAX*DIM_MAX];
   // entries that were loaded at least once
   bit a_loaded [DIM_MAX*DIM_MAX];
   bit b_loaded [DIM_MAX*DIM_MAX];

   // predicted register contents
   logic [DIM_W-1:0]   cfg_a_rows = 4'd1;
   logic [DIM_W-1:0]   cfg_a_cols = 4'd1;
   logic [DIM_W-1:0]   cfg_b_cols = 4'd1;
   logic               cfg_op     = OP_MULTIPLY;
   logic [POWER_W-1:0] cfg_power  = '0;

   result_word_type pending_results[$];
   int error_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   integer_matrix_multiply_power dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // 0 acts as 1, anything above the storage size acts as the storage size
   function automatic int eff_dim(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return int'(d);
   endfunction

   // acc = left (n x k) * right (k x m), wrapping at 32 bits
   task automatic mat_product(input int n, input int k, input int m,
                              input bit left_acc, input bit right_b);
      logic [VALUE_W-1:0] sum;
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < m; j++) begin
            sum = '0;
            for (int t = 0; t < k; t++) begin
               x = left_acc ? acc_mat[i*DIM_MAX+t] : a_mat[i*DIM_MAX+t];
               y = right_b ? b_mat[t*DIM_MAX+j] : a_mat[t*DIM_MAX+j];
               sum = sum + x * y;
            end
            tmp_mat[i*DIM_MAX+j] = sum;
         end
      end
      acc_mat = tmp_mat;
   endtask

   // queue an n x m matrix as result words, row-major
   function automatic void queue_matrix(input int n, input int m, input bit from_acc);
      result_word_type w;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < m; j++) begin
            w.row   = POS_W'(i);
            w.col   = POS_W'(j);
            w.value = from_acc ? acc_mat[i*DIM_MAX+j] : a_mat[i*DIM_MAX+j];
            w.last  = (i == n - 1) && (j == m - 1);
            w.error = 1'b0;
            pending_results.push_back(w);
         end
      end
   endfunction

   task automatic predict_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                               input logic [POS_W-1:0] col, input logic [VALUE_W-1:0] value);
      int nr;
      int nc;
      int mb;
      result_word_type w;
      nr = eff_dim(cfg_a_rows);
      nc = eff_dim(cfg_a_cols);
      mb = eff_dim(cfg_b_cols);
      case (mode)
         MODE_LOAD_A: a_mat[row*DIM_MAX+col] = value;
         MODE_LOAD_B: b_mat[row*DIM_MAX+col] = value;
         MODE_START: begin
            if (cfg_op == OP_MULTIPLY) begin
               mat_product(nr, nc, mb, 1'b0, 1'b1);
               queue_matrix(nr, mb, 1'b1);
            end else if (cfg_power <= 1) begin
               // power 0 or 1 hands back A as loaded
               queue_matrix(nr, nc, 1'b0);
            end else if (nr != nc) begin
               // power of a non-square A: one error word
               w.row   = '0;
               w.col   = '0;
               w.value = '0;
               w.last  = 1'b1;
               w.error = 1'b1;
               pending_results.push_back(w);
            end else begin
               mat_product(nr, nr, nr, 1'b0, 1'b0);
               for (int p = 2; p < cfg_power; p++) mat_product(nr, nr, nr, 1'b1, 1'b0);
               queue_matrix(nr, nr, 1'b1);
            end
         end
         default: ; // unused mode: no effect
      endcase
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with none expected", rsp_out_value, '0);
         end else begin
            want = pending_results.pop_front();
            check_field("out_row", 32'(rsp_out_row), 32'(want.row));
            check_field("out_col", 32'(rsp_out_col), 32'(want.col));
            check_field("out_value", rsp_out_value, want.value);
            check_field("last", 32'(rsp_last), 32'(want.last));
            check_field("error", 32'(rsp_error), 32'(want.error));
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 16) - 8;
         default: return $urandom();
      endcase
   endfunction

   // one request word; valid stays high on return so the next word can follow
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [VALUE_W-1:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == MODE_LOAD_A) a_loaded[row*DIM_MAX+col] = 1'b1;
      if (mode == MODE_LOAD_B) b_loaded[row*DIM_MAX+col] = 1'b1;
      if (mode != MODE_UNUSED) items_sent++;
      predict_item(mode, row, col, value);
   endtask

   // drop valid, let every expected word arrive, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         REG_A_ROWS:    cfg_a_rows = data[DIM_W-1:0];
         REG_A_COLS:    cfg_a_cols = data[DIM_W-1:0];
         REG_B_COLS:    cfg_b_cols = data[DIM_W-1:0];
         REG_OP_SELECT: cfg_op     = data[0];
         REG_POWER:     cfg_power  = data[POWER_W-1:0];
         default: ; // no register here
      endcase
   endtask

   task automatic set_job(input logic [CSR_DATA_W-1:0] rows, input logic [CSR_DATA_W-1:0] cols,
                          input logic [CSR_DATA_W-1:0] bcols, input logic [CSR_DATA_W-1:0] op,
                          input logic [CSR_DATA_W-1:0] pw);
      wait_idle();
      write_reg(REG_A_ROWS, rows);
      write_reg(REG_A_COLS, cols);
      write_reg(REG_B_COLS, bcols);
      write_reg(REG_OP_SELECT, op);
      write_reg(REG_POWER, pw);
   endtask

   // load whatever the job reads but was never loaded, then start it
   task automatic start_job();
      int nr;
      int nc;
      int mb;
      nr = eff_dim(cfg_a_rows);
      nc = eff_dim(cfg_a_cols);
      mb = eff_dim(cfg_b_cols);
      for (int i = 0; i < nr; i++)
         for (int t = 0; t < nc; t++)
            if (!a_loaded[i*DIM_MAX+t])
               send_word(MODE_LOAD_A, POS_W'(i), POS_W'(t), rand_value());
      if (cfg_op == OP_MULTIPLY) begin
         for (int t = 0; t < nc; t++)
            for (int j = 0; j < mb; j++)
               if (!b_loaded[t*DIM_MAX+j])
                  send_word(MODE_LOAD_B, POS_W'(t), POS_W'(j), rand_value());
      end
      send_word(MODE_START, POS_W'($urandom()), POS_W'($urandom()), $urandom());
   endtask

   // mostly small sizes; sometimes 0, the full size, or values beyond it
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 15))
         0: return 8'd0;
         1: return 8'd8;
         2: return CSR_DATA_W'($urandom_range(9, 15));
         3: return {4'($urandom()), 4'($urandom_range(1, 4))};
         default: return CSR_DATA_W'($urandom_range(1, 4));
      endcase
   endfunction

   // random registers, then a load sequence (full or partial), noise, start
   task automatic random_job();
      logic [CSR_DATA_W-1:0] rows;
      logic [CSR_DATA_W-1:0] cols;
      logic [CSR_DATA_W-1:0] bcols;
      logic [CSR_DATA_W-1:0] pw;
      logic                  op;
      int nr;
      int nc;
      int mb;
      op    = 1'($urandom_range(0, 1));
      rows  = pick_dim();
      cols  = (op == OP_POWER && $urandom_range(0, 3) != 0) ? rows : pick_dim();
      bcols = pick_dim();
      nr    = eff_dim(rows[DIM_W-1:0]);
      // keep long power chains on small matrices
      case ($urandom_range(0, 7))
         0: pw = 8'd0;
         1: pw = 8'd1;
         2: pw = (nr <= 2) ? 8'd255 : 8'd3;
         default: pw = POWER_W'($urandom_range(2, (nr > 4) ? 4 : 8));
      endcase
      if ($urandom_range(0, 3) == 0) pw = {7'($urandom_range(0, 127)), 1'b0} | pw;
      if (nr > 4 && pw > 4) pw = 8'd4;
      if (nr > 2 && pw > 8) pw = 8'd8;
      set_job(rows, cols, bcols, {7'($urandom()), op}, pw);
      nc = eff_dim(cfg_a_cols);
      mb = eff_dim(cfg_b_cols);

      if ($urandom_range(0, 1)) begin
         for (int i = 0; i < nr; i++)
            for (int t = 0; t < nc; t++)
               send_word(MODE_LOAD_A, POS_W'(i), POS_W'(t), rand_value());
      end else begin
         repeat ($urandom_range(0, nr * nc))
            send_word(MODE_LOAD_A, POS_W'($urandom_range(0, nr - 1)),
                      POS_W'($urandom_range(0, nc - 1)), rand_value());
      end
      if (cfg_op == OP_MULTIPLY) begin
         if ($urandom_range(0, 1)) begin
            for (int t = 0; t < nc; t++)
               for (int j = 0; j < mb; j++)
                  send_word(MODE_LOAD_B, POS_W'(t), POS_W'(j), rand_value());
         end else begin
            repeat ($urandom_range(0, nc * mb))
               send_word(MODE_LOAD_B, POS_W'($urandom_range(0, nc - 1)),
                         POS_W'($urandom_range(0, mb - 1)), rand_value());
         end
      end
      // noise: loads anywhere in storage and unused-mode words
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1))
            send_word(MODE_UNUSED, POS_W'($urandom()), POS_W'($urandom()), $urandom());
         else
            send_word(MODE_W'($urandom_range(0, 1)), POS_W'($urandom()), POS_W'($urandom()),
                      rand_value());
      end
      start_job();
      if ($urandom_range(0, 3) == 0) start_job();
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset sizes 1x1x1: products that wrap at 32 bits, unused mode
   task automatic test_multiply_wrap();
      send_word(MODE_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
      send_word(MODE_LOAD_B, 3'd0, 3'd0, 32'd2);
      send_word(MODE_START, 3'd7, 3'd7, 32'hffff_ffff);
      send_word(MODE_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
      send_word(MODE_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff);
      send_word(MODE_UNUSED, 3'd0, 3'd0, 32'h1234_5678);
      send_word(MODE_START, 3'd0, 3'd0, 32'h0);
      send_word(MODE_LOAD_A, 3'd7, 3'd7, 32'h7fff_ffff);
      send_word(MODE_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
   endtask

   // sizes of 0 and beyond the storage, masked register bits, unused index
   task automatic test_register_extremes();
      set_job(8'h00, 8'h00, 8'h00, 8'h02, 8'hff);
      start_job();
      set_job(8'h0f, 8'h01, 8'h18, {7'd0, OP_MULTIPLY}, 8'h80);
      write_reg(REG_POWER + 3'd1 + 3'($urandom_range(0, 2)), 8'hff);
      start_job();
   endtask

   // power 0, 1, 2 and 255 on square and non-square A
   task automatic test_power_cases();
      set_job(8'd2, 8'd3, 8'd1, {7'd0, OP_POWER}, 8'd1);
      start_job();
      wait_idle();
      write_reg(REG_POWER, 8'd2);
      start_job();
      set_job(8'd2, 8'd2, 8'd1, {7'd0, OP_POWER}, 8'd0);
      start_job();
      set_job(8'd2, 8'd2, 8'd1, {7'd0, OP_POWER}, 8'd255);
      start_job();
      set_job(8'd1, 8'd1, 8'd1, {7'd0, OP_POWER}, 8'd255);
      start_job();
   endtask

   task automatic test_random_jobs(input int send_pct, input int recv_pct);
      int phase_end;
      wait_idle();
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      phase_end     = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) random_job();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_multiply_wrap();
      test_register_extremes();
      test_power_cases();
      test_random_jobs(0, 0);
      test_random_jobs(67, 0);
      test_random_jobs(0, 67);
      test_random_jobs(33, 33);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
